>>> src/task_lifecycle_table_defines.svh
// Assertion macros shared by the checker files of the task lifecycle table.
// Depends on nothing; the including scope must provide clk_i and rst_ni.
`ifndef TASK_LIFECYCLE_TABLE_DEFINES_SVH
`define TASK_LIFECYCLE_TABLE_DEFINES_SVH

// Consequence holds in the same cycle as the antecedent.
`define TLT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequence holds in the cycle after the antecedent.
`define TLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/tlt_pkg.sv
// Types and constants of the task lifecycle table.
// Used by the top level (the RAM-backed table) and the checker.
package tlt_pkg;

  localparam logic [3:0] ACT_CREATE     = 4'd0;
  localparam logic [3:0] ACT_DESTROY    = 4'd1;
  localparam logic [3:0] ACT_QUEUE      = 4'd2;
  localparam logic [3:0] ACT_START      = 4'd3;
  localparam logic [3:0] ACT_COMPLETE   = 4'd4;
  localparam logic [3:0] ACT_FAIL       = 4'd5;
  localparam logic [3:0] ACT_CANCEL     = 4'd6;
  localparam logic [3:0] ACT_PAUSE      = 4'd7;
  localparam logic [3:0] ACT_RESUME     = 4'd8;
  localparam logic [3:0] ACT_ENABLE     = 4'd9;
  localparam logic [3:0] ACT_DISABLE    = 4'd10;
  localparam logic [3:0] ACT_SET_RETRY  = 4'd11;
  localparam logic [3:0] ACT_LOOKUP_KEY = 4'd12;
  localparam logic [3:0] ACT_LOOKUP_ID  = 4'd13;
  localparam logic [3:0] ACT_CLEAR      = 4'd14;

  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_REFUSED   = 3'd1;
  localparam logic [2:0] STS_FULL      = 3'd2;
  localparam logic [2:0] STS_BAD_PRIO  = 3'd3;
  localparam logic [2:0] STS_DUPLICATE = 3'd4;
  localparam logic [2:0] STS_NOT_FOUND = 3'd5;
  localparam logic [2:0] STS_BAD_STATE = 3'd6;

  localparam logic [2:0] PH_CREATED   = 3'd0;
  localparam logic [2:0] PH_QUEUED    = 3'd1;
  localparam logic [2:0] PH_RUNNING   = 3'd2;
  localparam logic [2:0] PH_PAUSED    = 3'd3;
  localparam logic [2:0] PH_COMPLETED = 3'd4;
  localparam logic [2:0] PH_CANCELLED = 3'd5;
  localparam logic [2:0] PH_FAILED    = 3'd6;
  localparam int unsigned PHASES = 7;

  localparam logic [3:0] PRIORITY_TOP = 4'd3;

  localparam logic CFG_ACCEPTING = 1'b0;
  localparam logic CFG_LOCKED    = 1'b1;

  typedef struct packed {
    logic [3:0]  action;
    logic [31:0] task_key;
    logic [3:0]  priority_req;
    logic        retry_on;
    logic [7:0]  retry_limit;
    logic [2:0]  query_state;
    logic [31:0] lookup_id;
  } tlt_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] task_id;
    logic [2:0]  task_state;
    logic [31:0] exec_count;
    logic [31:0] fault_count;
    logic [6:0]  state_count;
    logic [6:0]  task_total;
    logic [31:0] generation;
    logic [31:0] created_total;
    logic [31:0] completed_total;
    logic [31:0] failed_total;
    logic [31:0] cancelled_total;
  } tlt_out_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] id;
    logic [2:0]  phase;
    logic [1:0]  prio;
    logic        enabled;
    logic        retry_on;
    logic [7:0]  retry_limit;
    logic [7:0]  retry_spent;
    logic [31:0] runs;
    logic [31:0] failures;
  } tlt_entry_t;

endpackage

>>> src/tlt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module tlt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> src/task_lifecycle_table.sv
// Top level of the task lifecycle table: sequencer, slot scan and update.
// Depends on tlt_pkg and tlt_ram.
//
// An item enters on in_valid_i/in_ready_o and carries one action. The block
// then sweeps every slot of the entry RAM, one read a cycle, comparing each
// stored key (or id) and noting the lowest free slot. In the next cycle it
// applies the action, writes any created or changed entry back and registers
// exactly one result item, shown on out_valid_o/out_ready_i.
// The sweep is paced by the single RAM read port walked by the scan counter.
// The block takes one item at a time: in_ready_o is low from acceptance
// until the cycle after the result item is taken, so a stalled receiver
// simply holds the block. Configuration (accepting, locked) is written
// through cfg_we_i and takes effect on the next item; the user must write it
// only while no item is in flight, as the block itself does not enforce this.
// Reset clears every slot valid bit, the counters and the totals at once;
// no clearing pass is needed, and the block is ready right after reset.
module task_lifecycle_table #(
  parameter int unsigned TASK_SLOTS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tlt_pkg::tlt_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tlt_pkg::tlt_out_t out_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic              cfg_wdata_i
);

  localparam int unsigned IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned CW = $clog2(TASK_SLOTS + 1);
  localparam int unsigned EW = $bits(tlt_pkg::tlt_entry_t);
  localparam logic [IW-1:0] LAST_SLOT = IW'(TASK_SLOTS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]           state_q, state_d;
  tlt_pkg::tlt_in_t     in_q;
  logic [CW-1:0]        cnt_q;
  logic [IW-1:0]        rd_idx_q;
  logic                 rd_vld_q;
  logic                 match_q, free_q;
  logic [IW-1:0]        mslot_q, fslot_q;
  tlt_pkg::tlt_entry_t  ent_q;
  logic                 valid_q [TASK_SLOTS];
  logic [CW-1:0]        pcnt_q [tlt_pkg::PHASES];
  logic [CW-1:0]        pcnt_n [tlt_pkg::PHASES];
  logic [CW-1:0]        entries_q, entries_n;
  logic [31:0]          next_id_q, gen_q, gen_n;
  logic [31:0]          created_q, completed_q, failed_q, cancelled_q;
  logic                 accepting_q, locked_q;
  tlt_pkg::tlt_out_t    out_q;

  logic [EW-1:0]        rdata;
  tlt_pkg::tlt_entry_t  rd_ent, ne;
  logic                 hit;
  logic [2:0]           sts;
  logic                 chg, create_ok, destroy_ok, show, pc_inc, pc_dec;
  logic                 inc_completed, inc_failed, inc_cancelled;
  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  logic [6:0]           state_cnt;

  assign rd_ent = tlt_pkg::tlt_entry_t'(rdata);

  tlt_ram #(
    .Width (EW),
    .Depth (TASK_SLOTS)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (EW'(ne)),
    .raddr_i (cnt_q[IW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    hit = 1'b0;
    if (rd_vld_q && valid_q[rd_idx_q]) begin
      if (in_q.action == tlt_pkg::ACT_LOOKUP_ID) begin
        hit = (in_q.lookup_id != 32'd0) && (rd_ent.id == in_q.lookup_id);
      end else begin
        hit = (in_q.task_key != 32'd0) && (rd_ent.key == in_q.task_key);
      end
    end
  end

  always_comb begin
    sts           = tlt_pkg::STS_OK;
    chg           = 1'b0;
    create_ok     = 1'b0;
    destroy_ok    = 1'b0;
    inc_completed = 1'b0;
    inc_failed    = 1'b0;
    inc_cancelled = 1'b0;
    ne            = ent_q;
    unique case (in_q.action)
      tlt_pkg::ACT_CREATE: begin
        if (locked_q || !accepting_q || in_q.task_key == 32'd0) begin
          sts = tlt_pkg::STS_REFUSED;
        end else if (entries_q >= CW'(TASK_SLOTS) || !free_q) begin
          sts = tlt_pkg::STS_FULL;
        end else if (in_q.priority_req > tlt_pkg::PRIORITY_TOP) begin
          sts = tlt_pkg::STS_BAD_PRIO;
        end else if (match_q) begin
          sts = tlt_pkg::STS_DUPLICATE;
        end else begin
          ne.key          = in_q.task_key;
          ne.id           = next_id_q;
          ne.phase        = tlt_pkg::PH_CREATED;
          ne.prio         = in_q.priority_req[1:0];
          ne.enabled      = 1'b1;
          ne.retry_on     = 1'b0;
          ne.retry_limit  = 8'd0;
          ne.retry_spent  = 8'd0;
          ne.runs         = 32'd0;
          ne.failures     = 32'd0;
          create_ok       = 1'b1;
          chg             = 1'b1;
        end
      end
      tlt_pkg::ACT_DESTROY: begin
        if (locked_q) sts = tlt_pkg::STS_REFUSED;
        else if (!match_q) sts = tlt_pkg::STS_NOT_FOUND;
        else if (ent_q.phase == tlt_pkg::PH_RUNNING) sts = tlt_pkg::STS_BAD_STATE;
        else begin
          destroy_ok = 1'b1;
          chg        = 1'b1;
        end
      end
      tlt_pkg::ACT_QUEUE: begin
        if (!match_q) sts = tlt_pkg::STS_NOT_FOUND;
        else if (!ent_q.enabled || (ent_q.phase != tlt_pkg::PH_CREATED &&
                 ent_q.phase != tlt_pkg::PH_PAUSED)) sts = tlt_pkg::STS_BAD_STATE;
        else begin
          ne.phase = tlt_pkg::PH_QUEUED;
          chg      = 1'b1;
        end
      end
      tlt_pkg::ACT_START: begin
        if (!match_q) sts = tlt_pkg::STS_NOT_FOUND;
        else if (!ent_q.enabled || ent_q.phase != tlt_pkg::PH_QUEUED) begin
          sts = tlt_pkg::STS_BAD_STATE;
        end else begin
          ne.phase = tlt_pkg::PH_RUNNING;
          ne.runs  = ent_q.runs + 32'd1;
          chg      = 1'b1;
        end
      end
      tlt_pkg::ACT_COMPLETE: begin
        if (!match_q) sts = tlt_pkg::STS_NOT_FOUND;
        else if (ent_q.phase != tlt_pkg::PH_RUNNING) sts = tlt_pkg::STS_BAD_STATE;
        else begin
          ne.phase      = tlt_pkg::PH_COMPLETED;
          inc_completed = 1'b1;
          chg           = 1'b1;
        end
      end
      tlt_pkg::ACT_FAIL: begin
        if (!match_q) sts = tlt_pkg::STS_NOT_FOUND;
        else if (ent_q.phase != tlt_pkg::PH_RUNNING) sts = tlt_pkg::STS_BAD_STATE;
        else begin
          ne.failures = ent_q.failures + 32'd1;
          if (ent_q.retry_on && ent_q.retry_spent < ent_q.retry_limit) begin
            ne.retry_spent = ent_q.retry_spent + 8'd1;
            ne.phase       = tlt_pkg::PH_QUEUED;
          end else begin
            ne.phase   = tlt_pkg::PH_FAILED;
            inc_failed = 1'b1;
          end
          chg = 1'b1;
        end
      end
      tlt_pkg::ACT_CANCEL: begin
        if (!match_q) sts = tlt_pkg::STS_NOT_FOUND;
        else if (ent_q.phase == tlt_pkg::PH_COMPLETED ||
                 ent_q.phase == tlt_pkg::PH_FAILED) sts = tlt_pkg::STS_BAD_STATE;
        else begin
          ne.phase      = tlt_pkg::PH_CANCELLED;
          ne.enabled    = 1'b0;
          inc_cancelled = 1'b1;
          chg           = 1'b1;
        end
      end
      tlt_pkg::ACT_PAUSE: begin
        if (!match_q) sts = tlt_pkg::STS_NOT_FOUND;
        else if (ent_q.phase != tlt_pkg::PH_RUNNING &&
                 ent_q.phase != tlt_pkg::PH_QUEUED) sts = tlt_pkg::STS_BAD_STATE;
        else begin
          ne.phase = tlt_pkg::PH_PAUSED;
          chg      = 1'b1;
        end
      end
      tlt_pkg::ACT_RESUME: begin
        if (!match_q) sts = tlt_pkg::STS_NOT_FOUND;
        else if (ent_q.phase != tlt_pkg::PH_PAUSED) sts = tlt_pkg::STS_BAD_STATE;
        else begin
          ne.phase   = tlt_pkg::PH_QUEUED;
          ne.enabled = 1'b1;
          chg        = 1'b1;
        end
      end
      tlt_pkg::ACT_ENABLE: begin
        if (locked_q) sts = tlt_pkg::STS_REFUSED;
        else if (!match_q) sts = tlt_pkg::STS_NOT_FOUND;
        else if (ent_q.phase == tlt_pkg::PH_CANCELLED) sts = tlt_pkg::STS_BAD_STATE;
        else begin
          ne.enabled = 1'b1;
          chg        = 1'b1;
        end
      end
      tlt_pkg::ACT_DISABLE: begin
        if (locked_q) sts = tlt_pkg::STS_REFUSED;
        else if (!match_q) sts = tlt_pkg::STS_NOT_FOUND;
        else begin
          ne.enabled = 1'b0;
          if (ent_q.phase == tlt_pkg::PH_QUEUED) ne.phase = tlt_pkg::PH_PAUSED;
          chg = 1'b1;
        end
      end
      tlt_pkg::ACT_SET_RETRY: begin
        if (locked_q) sts = tlt_pkg::STS_REFUSED;
        else if (!match_q) sts = tlt_pkg::STS_NOT_FOUND;
        else begin
          ne.retry_on    = in_q.retry_on;
          ne.retry_limit = in_q.retry_limit;
          if (!in_q.retry_on) ne.retry_spent = 8'd0;
          chg = 1'b1;
        end
      end
      tlt_pkg::ACT_LOOKUP_KEY, tlt_pkg::ACT_LOOKUP_ID: begin
        if (!match_q) sts = tlt_pkg::STS_NOT_FOUND;
      end
      tlt_pkg::ACT_CLEAR: begin
        if (locked_q) sts = tlt_pkg::STS_REFUSED;
        else chg = 1'b1;
      end
      default: begin
        sts = tlt_pkg::STS_REFUSED;
      end
    endcase
  end

  always_comb begin
    show   = (match_q || create_ok) && in_q.action != tlt_pkg::ACT_CLEAR &&
             in_q.action <= tlt_pkg::ACT_CLEAR;
    pc_dec = chg && match_q && in_q.action != tlt_pkg::ACT_CLEAR;
    pc_inc = chg && in_q.action != tlt_pkg::ACT_DESTROY &&
             in_q.action != tlt_pkg::ACT_CLEAR;
    ram_we    = (state_q == ST_EXEC) && pc_inc;
    ram_waddr = create_ok ? fslot_q : mslot_q;
    gen_n     = chg ? gen_q + 32'd1 : gen_q;
    for (int p = 0; p < int'(tlt_pkg::PHASES); p++) begin
      pcnt_n[p] = pcnt_q[p];
      if (pc_dec && ent_q.phase == 3'(p)) pcnt_n[p] = pcnt_n[p] - CW'(1);
      if (pc_inc && ne.phase == 3'(p)) pcnt_n[p] = pcnt_n[p] + CW'(1);
      if (chg && in_q.action == tlt_pkg::ACT_CLEAR) pcnt_n[p] = '0;
    end
    if (chg && in_q.action == tlt_pkg::ACT_CLEAR) entries_n = '0;
    else if (create_ok) entries_n = entries_q + CW'(1);
    else if (destroy_ok) entries_n = entries_q - CW'(1);
    else entries_n = entries_q;
    state_cnt = (in_q.query_state < 3'(tlt_pkg::PHASES)) ?
                7'(pcnt_n[in_q.query_state]) : 7'd0;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_SCAN;
      ST_SCAN: if (rd_vld_q && rd_idx_q == LAST_SLOT) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_OUT;
      ST_OUT:  if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      match_q     <= 1'b0;
      free_q      <= 1'b0;
      entries_q   <= '0;
      next_id_q   <= 32'd1;
      gen_q       <= 32'd1;
      created_q   <= '0;
      completed_q <= '0;
      failed_q    <= '0;
      cancelled_q <= '0;
      accepting_q <= 1'b1;
      locked_q    <= 1'b0;
      for (int i = 0; i < int'(TASK_SLOTS); i++) valid_q[i] <= 1'b0;
      for (int p = 0; p < int'(tlt_pkg::PHASES); p++) pcnt_q[p] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == tlt_pkg::CFG_ACCEPTING) accepting_q <= cfg_wdata_i;
        else locked_q <= cfg_wdata_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          cnt_q    <= '0;
          rd_vld_q <= 1'b0;
          match_q  <= 1'b0;
          free_q   <= 1'b0;
        end
        ST_SCAN: begin
          rd_vld_q <= (cnt_q < CW'(TASK_SLOTS));
          if (cnt_q < CW'(TASK_SLOTS)) cnt_q <= cnt_q + CW'(1);
          if (hit && !match_q) match_q <= 1'b1;
          if (rd_vld_q && !valid_q[rd_idx_q] && !free_q) free_q <= 1'b1;
        end
        ST_EXEC: begin
          gen_q     <= gen_n;
          entries_q <= entries_n;
          for (int p = 0; p < int'(tlt_pkg::PHASES); p++) pcnt_q[p] <= pcnt_n[p];
          if (chg && in_q.action == tlt_pkg::ACT_CLEAR) begin
            for (int i = 0; i < int'(TASK_SLOTS); i++) valid_q[i] <= 1'b0;
            next_id_q   <= 32'd1;
            created_q   <= '0;
            completed_q <= '0;
            failed_q    <= '0;
            cancelled_q <= '0;
          end else begin
            if (create_ok) begin
              valid_q[fslot_q] <= 1'b1;
              next_id_q        <= next_id_q + 32'd1;
              created_q        <= created_q + 32'd1;
            end
            if (destroy_ok) valid_q[mslot_q] <= 1'b0;
            if (inc_completed) completed_q <= completed_q + 32'd1;
            if (inc_failed) failed_q <= failed_q + 32'd1;
            if (inc_cancelled) cancelled_q <= cancelled_q + 32'd1;
          end
        end
        ST_OUT: begin
          rd_vld_q <= 1'b0;
        end
        default: begin
          rd_vld_q <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) in_q <= in_i;
    rd_idx_q <= cnt_q[IW-1:0];
    if (state_q == ST_SCAN) begin
      if (hit && !match_q) begin
        mslot_q <= rd_idx_q;
        ent_q   <= rd_ent;
      end
      if (rd_vld_q && !valid_q[rd_idx_q] && !free_q) fslot_q <= rd_idx_q;
    end
    if (state_q == ST_EXEC) begin
      out_q.status          <= sts;
      out_q.task_id         <= show ? ne.id : 32'd0;
      out_q.task_state      <= show ? ne.phase : 3'd0;
      out_q.exec_count      <= show ? ne.runs : 32'd0;
      out_q.fault_count     <= show ? ne.failures : 32'd0;
      out_q.state_count     <= state_cnt;
      out_q.task_total      <= 7'(entries_n);
      out_q.generation      <= gen_n;
      if (chg && in_q.action == tlt_pkg::ACT_CLEAR) begin
        out_q.created_total   <= '0;
        out_q.completed_total <= '0;
        out_q.failed_total    <= '0;
        out_q.cancelled_total <= '0;
      end else begin
        out_q.created_total   <= created_q + 32'(create_ok);
        out_q.completed_total <= completed_q + 32'(inc_completed);
        out_q.failed_total    <= failed_q + 32'(inc_failed);
        out_q.cancelled_total <= cancelled_q + 32'(inc_cancelled);
      end
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign out_o       = out_q;

endmodule

>>> src/tlt_checker.sv
// Port-level checker of the task lifecycle table, bound to the top level.
// Depends on tlt_pkg and task_lifecycle_table_defines.svh.
`include "task_lifecycle_table_defines.svh"

module tlt_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input tlt_pkg::tlt_out_t out_o
);

  `TLT_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_o), "result item changed while stalled")
  `TLT_ASSERT_NEXT(a_one_item, in_valid_i && in_ready_o, !in_ready_o && !out_valid_o, "item accepted while another is in flight")
  `TLT_ASSERT_SAME(a_no_overlap, out_valid_o, !in_ready_o, "ready while a result item waits")

endmodule

bind task_lifecycle_table tlt_checker u_tlt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);
